@@ design/smrm_pkg.sv @@
package smrm_pkg;

  // Fixed field widths
  localparam int COUNT_W   = 12;
  localparam int MINUTE_W  = 6;
  localparam int ELAPSED_W = 16;
  localparam int DELAY_W   = 16;
  localparam int RATE_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST_CHAR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY      = 2'd2;

  // Configuration reset values
  localparam logic [RATE_W-1:0]  RST_FAST_CHAR_LIMIT = 24'd1000;
  localparam logic [DELAY_W-1:0] RST_FAST_DELAY      = 16'd100;
  localparam logic [DELAY_W-1:0] RST_SLOW_DELAY      = 16'd2000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_CLR,
    ST_RD,
    ST_UPD,
    ST_SUM,
    ST_SUML,
    ST_DVST,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mod_step;
    logic clr_start;
    logic clr_step;
    logic clr_all;
    logic upd;
    logic sum_rd;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic m_ok;
    logic ela_zero;
    logic ela_long;
    logic clr_none;
    logic clr_done;
    logic sum_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ design/smrm_ctrl.sv @@
module smrm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  smrm_pkg::sts_t sts,
  output smrm_pkg::cmd_t cmd
);

  smrm_pkg::state_t state_r;
  smrm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smrm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = smrm_pkg::ST_MOD;
      end
      smrm_pkg::ST_MOD: begin
        if (sts.m_ok) begin
          if (sts.ela_zero) begin
            state_nxt = smrm_pkg::ST_RD;
          end else if (sts.ela_long || sts.clr_none) begin
            state_nxt = smrm_pkg::ST_UPD;
          end else begin
            state_nxt = smrm_pkg::ST_CLR;
          end
        end
      end
      smrm_pkg::ST_CLR: begin
        if (sts.clr_done) state_nxt = smrm_pkg::ST_UPD;
      end
      smrm_pkg::ST_RD:   state_nxt = smrm_pkg::ST_UPD;
      smrm_pkg::ST_UPD:  state_nxt = smrm_pkg::ST_SUM;
      smrm_pkg::ST_SUM: begin
        if (sts.sum_last) state_nxt = smrm_pkg::ST_SUML;
      end
      smrm_pkg::ST_SUML: state_nxt = smrm_pkg::ST_DVST;
      smrm_pkg::ST_DVST: state_nxt = smrm_pkg::ST_DIV;
      smrm_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = smrm_pkg::ST_DONE;
      end
      smrm_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = smrm_pkg::ST_IDLE;
      end
      default: state_nxt = smrm_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      smrm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      smrm_pkg::ST_MOD: begin
        if (!sts.m_ok) begin
          cmd.mod_step = 1'b1;
        end else if (!sts.ela_zero) begin
          if (sts.ela_long) begin
            cmd.clr_all = 1'b1;
          end else if (!sts.clr_none) begin
            cmd.clr_start = 1'b1;
          end
        end
      end
      smrm_pkg::ST_CLR: begin
        cmd.clr_step = !sts.clr_done;
      end
      smrm_pkg::ST_RD: ;
      smrm_pkg::ST_UPD:  cmd.upd = 1'b1;
      smrm_pkg::ST_SUM:  cmd.sum_rd = 1'b1;
      smrm_pkg::ST_SUML: ;
      smrm_pkg::ST_DVST: cmd.div_start = 1'b1;
      smrm_pkg::ST_DIV:  cmd.div_step = !sts.div_done;
      smrm_pkg::ST_DONE: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/smrm_dp.sv @@
module smrm_dp #(
  parameter int BIN_COUNT = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smrm_pkg::cmd_t                      cmd,
  output smrm_pkg::sts_t                      sts,
  input  logic [smrm_pkg::COUNT_W-1:0]        in_char_count,
  input  logic [smrm_pkg::MINUTE_W-1:0]       in_minute_now,
  input  logic [smrm_pkg::ELAPSED_W-1:0]      in_minutes_elapsed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [smrm_pkg::DELAY_W-1:0]        out_send_delay,
  output logic [smrm_pkg::RATE_W-1:0]         out_chars_per_minute,
  input  logic                                cfg_we,
  input  logic [smrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smrm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IW   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CNTW = $clog2(BIN_COUNT + 1);
  localparam int SW   = smrm_pkg::RATE_W + IW;
  localparam int DCW  = $clog2(SW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(BIN_COUNT - 1);
  localparam logic [smrm_pkg::MINUTE_W:0] BIN_M = (smrm_pkg::MINUTE_W + 1)'(BIN_COUNT);
  localparam logic [smrm_pkg::ELAPSED_W-1:0] BIN_E = smrm_pkg::ELAPSED_W'(BIN_COUNT);
  localparam logic [CNTW-1:0] BIN_C = CNTW'(BIN_COUNT);

  // Configuration registers
  logic [smrm_pkg::RATE_W-1:0]  limit_r;
  logic [smrm_pkg::DELAY_W-1:0] fast_r;
  logic [smrm_pkg::DELAY_W-1:0] slow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= smrm_pkg::RST_FAST_CHAR_LIMIT;
      fast_r  <= smrm_pkg::RST_FAST_DELAY;
      slow_r  <= smrm_pkg::RST_SLOW_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        smrm_pkg::REG_FAST_CHAR_LIMIT: limit_r <= cfg_wdata;
        smrm_pkg::REG_FAST_DELAY:      fast_r  <= cfg_wdata[smrm_pkg::DELAY_W-1:0];
        smrm_pkg::REG_SLOW_DELAY:      slow_r  <= cfg_wdata[smrm_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic [smrm_pkg::COUNT_W-1:0]   cnt_r;
  logic [smrm_pkg::MINUTE_W-1:0]  m_r;
  logic [smrm_pkg::ELAPSED_W-1:0] ela_r;
  logic [smrm_pkg::DELAY_W-1:0]   delay_r;
  logic [smrm_pkg::RATE_W-1:0]    rate_r;
  logic [IW-1:0]                  m_idx;

  assign m_idx = m_r[IW-1:0];

  // Delay is picked from the rate left by the previous item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r   <= in_char_count;
      m_r     <= in_minute_now;
      ela_r   <= in_minutes_elapsed;
      delay_r <= (rate_r < limit_r) ? fast_r : slow_r;
    end else if (cmd.mod_step) begin
      m_r <= m_r - BIN_M[smrm_pkg::MINUTE_W-1:0];
    end
  end

  // Minute tracking state
  logic [IW-1:0]   last_r;
  logic [IW-1:0]   first_r;
  logic            first_vld_r;
  logic [CNTW-1:0] used_r;
  logic [IW-1:0]   first_eff;
  logic [IW-1:0]   fwd_dist;

  assign first_eff = first_vld_r ? first_r : m_idx;
  assign fwd_dist = (m_idx >= first_eff) ? (m_idx - first_eff)
                                         : IW'(BIN_COUNT - 1) - (first_eff - m_idx - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      first_r     <= '0;
      first_vld_r <= 1'b0;
      used_r      <= CNTW'(1);
    end else if (cmd.upd) begin
      first_r     <= first_eff;
      first_vld_r <= 1'b1;
      last_r      <= m_idx;
      if (used_r < BIN_C && last_r != m_idx) begin
        used_r <= CNTW'(fwd_dist) + CNTW'(1);
      end
    end
  end

  // Bin store with one valid bit per bin; an invalid bin reads as zero
  logic [smrm_pkg::RATE_W-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0]        vld_r;
  logic [IW-1:0]               ptr_r;
  logic [IW-1:0]               sptr_r;
  logic [IW-1:0]               rd_addr;
  logic [smrm_pkg::RATE_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  logic [smrm_pkg::RATE_W-1:0] bin_data;
  logic [smrm_pkg::RATE_W:0]   add_sum;
  logic [smrm_pkg::RATE_W-1:0] wr_data;
  logic [IW-1:0]               ptr_inc;
  logic [IW-1:0]               last_inc;

  assign rd_addr  = cmd.sum_rd ? sptr_r : m_idx;
  assign bin_data = rd_vld_r ? rd_data_r : '0;
  assign add_sum  = {1'b0, bin_data} + (smrm_pkg::RATE_W + 1)'(cnt_r);
  assign wr_data  = (ela_r != '0) ? smrm_pkg::RATE_W'(cnt_r)
                  : (add_sum[smrm_pkg::RATE_W] ? smrm_pkg::RATE_MAX
                                               : add_sum[smrm_pkg::RATE_W-1:0]);
  assign ptr_inc  = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
  assign last_inc = (last_r == LAST_IDX) ? '0 : last_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[m_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clr_all) begin
      vld_r <= '0;
    end else if (cmd.clr_step) begin
      vld_r[ptr_r] <= 1'b0;
    end else if (cmd.upd) begin
      vld_r[m_idx] <= 1'b1;
    end
  end

  // Clear pointer walks the skipped bins
  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      ptr_r <= last_inc;
    end else if (cmd.clr_step) begin
      ptr_r <= ptr_inc;
    end
  end

  // Sum sweep over all bins, one read a cycle
  logic          acc_en_r;
  logic [SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.sum_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      sptr_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cmd.sum_rd) sptr_r <= sptr_r + 1'b1;
      if (acc_en_r) sum_r <= sum_r + SW'(bin_data);
    end
  end

  // Restoring divider, one quotient bit a cycle
  logic [CNTW-1:0] rem_r;
  logic [SW-1:0]   quo_r;
  logic [DCW-1:0]  dcnt_r;
  logic [CNTW:0]   rem_sh;
  logic [CNTW:0]   rem_diff;
  logic            q_bit;

  assign rem_sh   = {rem_r, quo_r[SW-1]};
  assign rem_diff = rem_sh - {1'b0, used_r};
  assign q_bit    = (rem_sh >= {1'b0, used_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DCW'(SW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= sum_r;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[CNTW-1:0] : rem_sh[CNTW-1:0];
      quo_r <= {quo_r[SW-2:0], q_bit};
    end
  end

  // Rate and output register
  logic [smrm_pkg::RATE_W-1:0]  rate_nxt;
  logic                         out_valid_r;
  logic [smrm_pkg::DELAY_W-1:0] out_delay_r;
  logic [smrm_pkg::RATE_W-1:0]  out_rate_r;

  assign rate_nxt = (|quo_r[SW-1:smrm_pkg::RATE_W]) ? smrm_pkg::RATE_MAX
                                                    : quo_r[smrm_pkg::RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      rate_r      <= rate_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_delay_r <= delay_r;
      out_rate_r  <= rate_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_delay       = out_delay_r;
  assign out_chars_per_minute = out_rate_r;

  // Status
  always_comb begin
    sts          = '0;
    sts.m_ok     = ({1'b0, m_r} < BIN_M);
    sts.ela_zero = (ela_r == '0);
    sts.ela_long = (ela_r >= BIN_E);
    sts.clr_none = (m_idx == last_r);
    sts.clr_done = (ptr_r == m_idx);
    sts.sum_last = (sptr_r == LAST_IDX);
    sts.div_done = (dcnt_r == '0);
    sts.out_free = !out_valid_r || !out_stall;
  end

endmodule

@@ design/sliding_minute_rate_meter_unit.sv @@
// Sliding-window character rate meter for send flood control. Each input
// transfer carries a line's character count, the minute of the hour and the
// minutes since the previous send; the result transfer returns the delay to
// wait before this send (chosen from the rate left by the previous send) and
// the updated average characters per minute over the bins used so far. One
// item is processed at a time. The time from one input transfer to the next
// grows for a minute of 60 or more, for the bin read of a same-minute add,
// with the number of skipped bins when bins between minutes are cleared, and
// with output stalls. It is set by the bin store's single read port, swept
// once per item to form the sum, and by the bit-serial divider (one quotient
// bit per cycle).
// A new item is accepted while the previous result still waits in the output
// register. Configuration writes are taken at any time but must only be issued
// while the block is idle.
module sliding_minute_rate_meter_unit #(
  parameter int BIN_COUNT = 60
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [smrm_pkg::COUNT_W-1:0]       in_char_count,
  input  logic [smrm_pkg::MINUTE_W-1:0]      in_minute_now,
  input  logic [smrm_pkg::ELAPSED_W-1:0]     in_minutes_elapsed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [smrm_pkg::DELAY_W-1:0]       out_send_delay,
  output logic [smrm_pkg::RATE_W-1:0]        out_chars_per_minute,
  input  logic                               cfg_we,
  input  logic [smrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smrm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  smrm_pkg::cmd_t cmd;
  smrm_pkg::sts_t sts;

  smrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smrm_dp #(
    .BIN_COUNT (BIN_COUNT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_char_count        (in_char_count),
    .in_minute_now        (in_minute_now),
    .in_minutes_elapsed   (in_minutes_elapsed),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_delay       (out_send_delay),
    .out_chars_per_minute (out_chars_per_minute),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

endmodule

@@ tb/sv/sliding_minute_rate_meter_checker.sv @@
// Watches the send and result channels of the rate meter, keeps its own copy
// of the minute bins and registers, and compares every result transfer with
// the oldest outstanding prediction.
module sliding_minute_rate_meter_checker
  import smrm_pkg::*;
#(
  parameter int BIN_COUNT = 60
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [COUNT_W-1:0]    in_char_count,
  input  logic [MINUTE_W-1:0]   in_minute_now,
  input  logic [ELAPSED_W-1:0]  in_minutes_elapsed,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DELAY_W-1:0]    out_send_delay,
  input  logic [RATE_W-1:0]     out_chars_per_minute,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    checked_count
);

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [RATE_W-1:0]  rate;
  } send_result_t;

  send_result_t expected_sends[$];

  // predicted meter state
  logic [RATE_W-1:0]   minute_tally [BIN_COUNT];
  logic [MINUTE_W-1:0] last_min;
  logic [MINUTE_W-1:0] first_min;
  logic                first_seen;
  logic [6:0]          bins_filled;
  logic [RATE_W-1:0]   avg_rate;

  // predicted register copies
  logic [RATE_W-1:0]  limit_reg;
  logic [DELAY_W-1:0] fast_reg;
  logic [DELAY_W-1:0] slow_reg;

  // one send: pick the delay from the old rate, update bins, recompute rate
  task automatic advance_meter(input logic [COUNT_W-1:0] cnt,
                               input logic [MINUTE_W-1:0] min_raw,
                               input logic [ELAPSED_W-1:0] gap,
                               output send_result_t res);
    int unsigned       m;
    int unsigned       span;
    int unsigned       idx;
    int unsigned       i;
    logic [RATE_W:0]   added;
    logic [RATE_W-1:0] wr;
    longint unsigned   total;
    m = min_raw % BIN_COUNT;
    res.delay = (avg_rate < limit_reg) ? fast_reg : slow_reg;
    wr = RATE_W'(cnt);
    if (gap == 0) begin
      // same minute: accumulate, saturating
      added = minute_tally[m] + cnt;
      wr = (added > RATE_MAX) ? RATE_MAX : added[RATE_W-1:0];
    end else if (gap < BIN_COUNT) begin
      // clear bins strictly between last minute and this one, wrapping
      span = (m + BIN_COUNT - last_min) % BIN_COUNT;
      idx = last_min;
      for (i = 1; i < span; i++) begin
        idx = (idx + 1) % BIN_COUNT;
        minute_tally[idx] = '0;
      end
    end else begin
      for (i = 0; i < BIN_COUNT; i++) minute_tally[i] = '0;
    end
    if (!first_seen) begin
      first_min = MINUTE_W'(m);
      first_seen = 1'b1;
    end
    if (bins_filled < BIN_COUNT && last_min != m)
      bins_filled = 7'((m + BIN_COUNT - first_min) % BIN_COUNT + 1);
    minute_tally[m] = wr;
    last_min = MINUTE_W'(m);
    total = 0;
    for (i = 0; i < BIN_COUNT; i++) total += minute_tally[i];
    total = total / bins_filled;
    avg_rate = (total > RATE_MAX) ? RATE_MAX : total[RATE_W-1:0];
    res.rate = avg_rate;
  endtask

  always @(posedge clk) begin
    send_result_t want;
    send_result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < BIN_COUNT; i++) minute_tally[i] = '0;
      last_min    = '0;
      first_min   = '0;
      first_seen  = 1'b0;
      bins_filled = 7'd1;
      avg_rate    = '0;
      limit_reg   = RST_FAST_CHAR_LIMIT;
      fast_reg    = RST_FAST_DELAY;
      slow_reg    = RST_SLOW_DELAY;
      expected_sends.delete();
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_sends.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result with nothing expected: delay %0d rate %0d",
                     out_send_delay, out_chars_per_minute);
        end else begin
          want = expected_sends.pop_front();
          checked_count++;
          if (want.delay !== out_send_delay || want.rate !== out_chars_per_minute) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: delay exp %0d got %0d, rate exp %0d got %0d",
                       checked_count, want.delay, out_send_delay,
                       want.rate, out_chars_per_minute);
          end
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FAST_CHAR_LIMIT: limit_reg = cfg_wdata[RATE_W-1:0];
          REG_FAST_DELAY:      fast_reg  = cfg_wdata[DELAY_W-1:0];
          REG_SLOW_DELAY:      slow_reg  = cfg_wdata[DELAY_W-1:0];
          default: ;
        endcase
      end
      // send transfer: predict its result
      if (in_valid && !in_stall) begin
        advance_meter(in_char_count, in_minute_now, in_minutes_elapsed, fresh);
        expected_sends.push_back(fresh);
      end
    end
    pending_count = expected_sends.size();
  end

endmodule

@@ tb/sv/sliding_minute_rate_meter_unit_tb.sv @@
module sliding_minute_rate_meter_unit_tb;
  import smrm_pkg::*;

  localparam int BINS        = 60;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 8;
  localparam int PHASE_SENDS = 212;
  localparam int SAT_SENDS   = 16;

  // idle profiles: none, sender gaps, receiver stalls, both
  localparam int SEND_IDLE [4] = '{0, 80, 0, 29};
  localparam int RECV_STALL [4] = '{0, 0, 80, 29};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COUNT_W-1:0]    in_char_count = '0;
  logic [MINUTE_W-1:0]   in_minute_now = '0;
  logic [ELAPSED_W-1:0]  in_minutes_elapsed = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DELAY_W-1:0]    out_send_delay;
  logic [RATE_W-1:0]     out_chars_per_minute;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fails;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int wall_minute = 0;
  int sends_made = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sliding_minute_rate_meter_unit #(.BIN_COUNT(BINS)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_count       (in_char_count),
    .in_minute_now       (in_minute_now),
    .in_minutes_elapsed  (in_minutes_elapsed),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_delay      (out_send_delay),
    .out_chars_per_minute(out_chars_per_minute),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  sliding_minute_rate_meter_checker #(.BIN_COUNT(BINS)) u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_count       (in_char_count),
    .in_minute_now       (in_minute_now),
    .in_minutes_elapsed  (in_minutes_elapsed),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_delay      (out_send_delay),
    .out_chars_per_minute(out_chars_per_minute),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .fail_count          (fails),
    .pending_count       (pending),
    .checked_count       (checked)
  );

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending);
    $display("** sliding_minute_rate_meter_unit: FAILED **");
    $finish;
  end

  // present one send and hold it until the transfer
  task automatic send_item(input logic [COUNT_W-1:0] cnt, input logic [MINUTE_W-1:0] mn,
                           input logic [ELAPSED_W-1:0] gap);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_char_count      <= cnt;
    in_minute_now      <= mn;
    in_minutes_elapsed <= gap;
    wall_minute = mn % BINS;
    sends_made++;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly sends whose minute follows the elapsed time, some noise
  task automatic send_random();
    logic [COUNT_W-1:0]   cnt;
    logic [MINUTE_W-1:0]  mn;
    logic [ELAPSED_W-1:0] gap;
    int                   sel;
    if ($urandom_range(9) == 0) cnt = $urandom_range(1) ? '1 : '0;
    else cnt = COUNT_W'($urandom);
    if ($urandom_range(99) < 90) begin
      sel = $urandom_range(99);
      if (sel < 60) gap = '0;
      else if (sel < 90) gap = ELAPSED_W'($urandom_range(5, 1));
      else if (sel < 96) gap = ELAPSED_W'($urandom_range(59, 6));
      else if (sel < 98) gap = '1;
      else gap = ELAPSED_W'($urandom_range(65535, 60));
      mn = MINUTE_W'((wall_minute + gap) % BINS);
    end else begin
      mn = MINUTE_W'($urandom_range(63));
      if ($urandom_range(3) == 0) gap = ELAPSED_W'($urandom);
      else gap = ELAPSED_W'($urandom_range(3));
    end
    send_item(cnt, mn, gap);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] fd,
                              input logic [CFG_DATA_W-1:0] sd);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FAST_CHAR_LIMIT;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_index <= REG_FAST_DELAY;
    cfg_wdata <= fd;
    @(negedge clk);
    cfg_index <= REG_SLOW_DELAY;
    cfg_wdata <= sd;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_sends();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] fd;
    logic [CFG_DATA_W-1:0] sd;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values; first send pins minute 0
    send_item(12'd0, 6'd0, 16'd0);
    // repeated full counts pile up in bin 0
    repeat (SAT_SENDS) send_item(12'hFFF, 6'd0, 16'd0);
    send_item(12'hFFF, 6'd1, 16'd0);
    // back to the first minute: one bin used again
    send_item(12'd1, 6'd0, 16'd0);
    send_item(12'd123, 6'd1, 16'd1);
    send_item(12'hFFF, 6'd5, 16'd4);
    send_item(12'd7, 6'd5, 16'd0);
    send_item(12'd2000, 6'd58, 16'd53);
    // skipped bins across the hour wrap
    send_item(12'd300, 6'd2, 16'd4);
    // minute unchanged although time passed
    send_item(12'd55, 6'd2, 16'd1);
    // out-of-range minutes fold back
    send_item(12'hFFF, 6'd61, 16'd59);
    send_item(12'd0, 6'd60, 16'd0);
    // long pauses clear every bin
    send_item(12'hFFF, 6'd63, 16'd60);
    send_item(12'd1, 6'd62, 16'hFFFF);
    // full window of bins in use
    send_item(12'd2048, 6'd59, 16'd0);
    send_item(12'hFFF, 6'd0, 16'd1);
    send_item(12'd0, 6'd31, 16'd32768);
    send_item(12'd42, 6'd42, 16'd11);
    send_item(12'hAAA, 6'd7, 16'd25);
    drain_sends();

    // random phases with varied registers and idle profiles
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lim = '0;         fd = 24'hFFFF; sd = '0;      end
        1: begin lim = 24'hFFFFFF; fd = '0;       sd = 24'hFFFF; end
        5: begin lim = CFG_DATA_W'($urandom); fd = CFG_DATA_W'($urandom);
                 sd = CFG_DATA_W'($urandom); end
        7: begin lim = RST_FAST_CHAR_LIMIT; fd = RST_FAST_DELAY; sd = RST_SLOW_DELAY; end
        default: begin
          lim = CFG_DATA_W'($urandom_range(20000));
          fd  = CFG_DATA_W'($urandom);
          sd  = CFG_DATA_W'($urandom);
        end
      endcase
      program_regs(lim, fd, sd);
      idle_pct  = SEND_IDLE[ph % 4];
      stall_pct = RECV_STALL[ph % 4];
      repeat (PHASE_SENDS) send_random();
      drain_sends();
    end
    stall_pct = 0;
    repeat (160) @(posedge clk);

    $display("covered %0d sends (%0d checked) incl. a same-minute burst,", sends_made,
             checked);
    $display("wrap and long-pause clears, %0d register settings, four idle profiles", PHASES);
    if (fails == 0 && pending == 0) begin
      $display("** sliding_minute_rate_meter_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fails, pending);
      $display("** sliding_minute_rate_meter_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sliding_minute_rate_meter_unit.f @@
design/smrm_pkg.sv
design/smrm_ctrl.sv
design/smrm_dp.sv
design/sliding_minute_rate_meter_unit.sv
tb/sv/sliding_minute_rate_meter_checker.sv
tb/sv/sliding_minute_rate_meter_unit_tb.sv
